// File: rtl/ictc_pkg.sv
// Shared types and constants for the address class cache.
package ictc_pkg;

  typedef enum logic [1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_FAIL  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_DB_FAIL_LIMIT   = 2'd0,
    REG_FAIL_CHECK_LIM  = 2'd1,
    REG_SWEEP_INTERVAL  = 2'd2,
    REG_ENTRY_LIFETIME  = 2'd3
  } reg_idx_t;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 72;
  localparam int OutDataW = 8;

  localparam logic [7:0]  RstDbFailLimit  = 8'd5;
  localparam logic [15:0] RstFailCheckLim = 16'd100;
  localparam logic [31:0] RstSweepIntv    = 32'd10000;
  localparam logic [31:0] RstLifetime     = 32'd3600000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]  db_fail_limit;
    logic [15:0] fail_check_limit;
    logic [31:0] sweep_interval;
    logic [31:0] entry_lifetime;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic cls;
    logic [31:0] addr;
    logic [31:0] stamp;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/ictc_regs.sv
// Configuration register file behind the APB-style port.
module ictc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ictc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [ictc_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [ictc_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready,
  output ictc_pkg::cfg_t                cfg
);
  import ictc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_DB_FAIL_LIMIT:  cfg_nxt.db_fail_limit    = cfg_pwdata[7:0];
        REG_FAIL_CHECK_LIM: cfg_nxt.fail_check_limit = cfg_pwdata[15:0];
        REG_SWEEP_INTERVAL: cfg_nxt.sweep_interval   = cfg_pwdata;
        REG_ENTRY_LIFETIME: cfg_nxt.entry_lifetime   = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DB_FAIL_LIMIT:  cfg_prdata = {24'd0, cfg_r.db_fail_limit};
      REG_FAIL_CHECK_LIM: cfg_prdata = {16'd0, cfg_r.fail_check_limit};
      REG_SWEEP_INTERVAL: cfg_prdata = cfg_r.sweep_interval;
      REG_ENTRY_LIFETIME: cfg_prdata = cfg_r.entry_lifetime;
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.db_fail_limit    <= RstDbFailLimit;
      cfg_r.fail_check_limit <= RstFailCheckLim;
      cfg_r.sweep_interval   <= RstSweepIntv;
      cfg_r.entry_lifetime   <= RstLifetime;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/ictc_ctrl.sv
// Controller: clearing pass, item accept, table scan and result hand-off.
module ictc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ictc_pkg::sts_t sts,
  output ictc_pkg::cmd_t cmd
);
  import ictc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// File: rtl/ictc_dp.sv
// Datapath: slot memory, scan pipeline, counters and output register.
module ictc_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ictc_pkg::cfg_t                cfg,
  input  ictc_pkg::cmd_t                cmd,
  output ictc_pkg::sts_t                sts,
  input  logic [ictc_pkg::InDataW-1:0]  in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ictc_pkg::OutDataW-1:0] out_tdata
);
  import ictc_pkg::*;

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_DEPTH - 1);

  slot_t mem [TABLE_DEPTH];
  slot_t rd_word_r;
  slot_t wd;
  logic  we;
  logic [IDXW-1:0] wa;

  logic [IDXW-1:0] clr_idx_r, clr_idx_nxt;
  logic [IDXW-1:0] rd_idx_r, rd_idx_nxt;
  logic            rd_act_r, rd_act_nxt;
  logic [IDXW-1:0] pidx_r;
  logic            pv_r;

  func_t       func_r;
  logic [31:0] ip_r, now_r;
  logic        cls_r, go_r;
  logic        found0_r, found0_nxt, found1_r, found1_nxt;
  logic        free_found_r, free_found_nxt;
  logic [IDXW-1:0] free_idx_r, free_idx_nxt;

  logic [8:0]  fail_cnt_r, fail_cnt_nxt;
  logic [15:0] forced_r, forced_nxt;
  logic [31:0] last_sweep_r, last_sweep_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic        known_r, known_nxt, prem_r, prem_nxt, drop_r, drop_nxt;

  logic [31:0] in_ip, in_now;
  logic        in_cls, in_go;
  logic        dup, sweep_hit, insert, forced_ok;

  assign in_ip  = in_tdata[31:0];
  assign in_cls = in_tdata[32];
  assign in_now = in_tdata[64:33];
  assign in_go  = (in_now - last_sweep_r) >= cfg.sweep_interval;

  assign dup       = cls_r ? found1_r : found0_r;
  assign sweep_hit = pv_r && (func_r == FUNC_TICK) && go_r && rd_word_r.vld &&
                     ((now_r - rd_word_r.stamp) >= cfg.entry_lifetime);
  assign insert    = cmd.fin && (func_r == FUNC_ADD) && !dup && free_found_r;
  assign forced_ok = (fail_cnt_r > {1'b0, cfg.db_fail_limit}) &&
                     (forced_r < cfg.fail_check_limit);

  assign sts.clr_last  = (clr_idx_r == LAST);
  assign sts.scan_done = pv_r && (pidx_r == LAST);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, drop_r, prem_r, known_r};

  // single write port shared by clear pass, sweep and insert
  always_comb begin
    wd       = '0;
    wd.cls   = cls_r;
    wd.addr  = ip_r;
    wd.stamp = now_r;
    wd.vld   = insert;
    we       = 1'b0;
    wa       = free_idx_r;
    if (cmd.clear) begin
      we = 1'b1;
      wa = clr_idx_r;
    end else if (sweep_hit) begin
      we = 1'b1;
      wa = pidx_r;
    end else if (insert) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_act_r) rd_word_r <= mem[rd_idx_r];
  end

  // read issue counter; read data lands in rd_word_r on the next cycle
  always_comb begin
    rd_act_nxt  = rd_act_r;
    rd_idx_nxt  = rd_idx_r;
    clr_idx_nxt = clr_idx_r;
    if (cmd.clear && !sts.clr_last) clr_idx_nxt = clr_idx_r + 1'b1;
    if (cmd.accept) begin
      rd_act_nxt = 1'b1;
      rd_idx_nxt = '0;
    end else if (rd_act_r) begin
      if (rd_idx_r == LAST) rd_act_nxt = 1'b0;
      else                  rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_comb begin
    found0_nxt     = found0_r;
    found1_nxt     = found1_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    if (cmd.accept) begin
      found0_nxt     = 1'b0;
      found1_nxt     = 1'b0;
      free_found_nxt = 1'b0;
    end else if (pv_r) begin
      if (rd_word_r.vld && (rd_word_r.addr == ip_r)) begin
        if (rd_word_r.cls) found1_nxt = 1'b1;
        else               found0_nxt = 1'b1;
      end
      // take the lowest free slot
      if (!rd_word_r.vld && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = pidx_r;
      end
    end
  end

  always_comb begin
    fail_cnt_nxt   = fail_cnt_r;
    forced_nxt     = forced_r;
    last_sweep_nxt = last_sweep_r;
    known_nxt      = known_r;
    prem_nxt       = prem_r;
    drop_nxt       = drop_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) out_tvalid_nxt = 1'b0;
    if (cmd.fin) begin
      out_tvalid_nxt = 1'b1;
      known_nxt      = 1'b0;
      prem_nxt       = 1'b0;
      drop_nxt       = 1'b0;
      case (func_r)
        FUNC_CHECK: begin
          known_nxt = found0_r || found1_r;
          prem_nxt  = !found0_r && found1_r;
          if (forced_ok) begin
            forced_nxt = forced_r + 16'd1;
            known_nxt  = 1'b1;
            prem_nxt   = 1'b0;
          end else begin
            forced_nxt = '0;
          end
        end
        FUNC_ADD: begin
          fail_cnt_nxt = '0;
          drop_nxt     = !dup && !free_found_r;
        end
        FUNC_FAIL: begin
          // wrap back once past the limit, then count this failure
          if (fail_cnt_r > {1'b0, cfg.db_fail_limit}) fail_cnt_nxt = 9'd1;
          else                                       fail_cnt_nxt = fail_cnt_r + 9'd1;
          forced_nxt = '0;
        end
        FUNC_TICK: begin
          if (go_r) last_sweep_nxt = now_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r    <= '0;
      rd_act_r     <= 1'b0;
      pv_r         <= 1'b0;
      fail_cnt_r   <= '0;
      forced_r     <= '0;
      last_sweep_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      clr_idx_r    <= clr_idx_nxt;
      rd_act_r     <= rd_act_nxt;
      pv_r         <= rd_act_r;
      fail_cnt_r   <= fail_cnt_nxt;
      forced_r     <= forced_nxt;
      last_sweep_r <= last_sweep_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    pidx_r       <= rd_idx_r;
    found0_r     <= found0_nxt;
    found1_r     <= found1_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    known_r      <= known_nxt;
    prem_r       <= prem_nxt;
    drop_r       <= drop_nxt;
    if (cmd.accept) begin
      func_r <= func_t'(in_tuser);
      ip_r   <= in_ip;
      cls_r  <= in_cls;
      now_r  <= in_now;
      go_r   <= in_go;
    end
  end

endmodule

// File: rtl/ip_class_cache_with_ttl_unit.sv
// Top level of the address class cache with entry lifetime and failure mode.
//
//   channel  dir  signals                       contents
//   in_      in   tvalid tready tdata tuser     request beat: func, ip, class, time
//   out_     out  tvalid tready tdata           result beat: known, premium, dropped
//   cfg_     in   psel penable pwrite paddr ..  four configuration registers
//
// Every request scans the whole slot memory, one slot read per cycle, and no
// new request is taken until the last result is in the output register.
// After reset a clearing pass marks all slots free; no request is taken
// meanwhile, configuration writes are.
// A finished result waits in the output register; a stalled out_tready holds
// the block in its final step until that register frees up.
module ip_class_cache_with_ttl_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] ip, [32] is_premium, [64:33] now_ms, [71:65] zero
  input  logic [ictc_pkg::InDataW-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] known, [1] premium, [2] dropped, [7:3] zero
  output logic [ictc_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ictc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [ictc_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [ictc_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import ictc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ictc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ictc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ictc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: verif/tb_ip_class_cache_with_ttl_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the address class cache with entry lifetime and failure mode.
module tb_ip_class_cache_with_ttl_unit;
  import ictc_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 16;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic dropped;
    logic premium;
    logic known;
  } verdict_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  ip_class_cache_with_ttl_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] ip, [32] is_premium, [64:33] now_ms, [71:65] zero
    .in_tuser   (in_tuser),     // [1:0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [0] known, [1] premium, [2] dropped, [7:3] zero
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predicted cache contents and registers
  logic        slot_used [TABLE_DEPTH];
  logic [31:0] slot_ip   [TABLE_DEPTH];
  logic        slot_prem [TABLE_DEPTH];
  logic [31:0] slot_born [TABLE_DEPTH];
  logic [8:0]  fail_cnt;
  logic [15:0] forced_cnt;
  logic [31:0] last_sweep_ms;
  logic [7:0]  lim_fail;
  logic [15:0] lim_forced;
  logic [31:0] sweep_gap;
  logic [31:0] lifetime;

  verdict_t    pending_verdicts[$];
  logic [31:0] addr_pool[POOL_SIZE];
  logic [31:0] wall_ms;
  int          in_idle_pct;
  int          out_stall_pct;
  int          errors;
  int          beat_idx;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic bit cache_holds(input logic [31:0] ip, input logic cls);
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (slot_used[s] && slot_ip[s] == ip && slot_prem[s] == cls) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t cache_predict(input func_t fn, input logic [31:0] ip,
                                             input logic cls, input logic [31:0] now);
    verdict_t    v;
    int          free_idx;
    logic [31:0] age;
    v = '0;
    free_idx = -1;
    case (fn)
      FUNC_CHECK: begin
        if (cache_holds(ip, 1'b0)) begin
          v.known = 1'b1;
        end else if (cache_holds(ip, 1'b1)) begin
          v.known   = 1'b1;
          v.premium = 1'b1;
        end
        // backend down: answer non-premium for a bounded run of checks
        if (fail_cnt > {1'b0, lim_fail} && forced_cnt < lim_forced) begin
          forced_cnt = forced_cnt + 16'd1;
          v.known   = 1'b1;
          v.premium = 1'b0;
        end else begin
          forced_cnt = '0;
        end
      end
      FUNC_ADD: begin
        fail_cnt = '0;
        if (!cache_holds(ip, cls)) begin
          for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
            if (!slot_used[s]) free_idx = s;
          end
          if (free_idx < 0) begin
            v.dropped = 1'b1;
          end else begin
            slot_used[free_idx] = 1'b1;
            slot_ip[free_idx]   = ip;
            slot_prem[free_idx] = cls;
            slot_born[free_idx] = now;
          end
        end
      end
      FUNC_FAIL: begin
        if (fail_cnt > {1'b0, lim_fail}) fail_cnt = '0;
        fail_cnt   = fail_cnt + 9'd1;
        forced_cnt = '0;
      end
      default: begin
        age = now - last_sweep_ms;
        if (age >= sweep_gap) begin
          last_sweep_ms = now;
          for (int s = 0; s < TABLE_DEPTH; s++) begin
            age = now - slot_born[s];
            if (slot_used[s] && age >= lifetime) slot_used[s] = 1'b0;
          end
        end
      end
    endcase
    return v;
  endfunction

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_error($sformatf("result beat %0d with nothing pending", beat_idx));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.known)
            report_error($sformatf("beat %0d known got %b want %b", beat_idx,
                                   out_tdata[0], want.known));
          if (out_tdata[1] !== want.premium)
            report_error($sformatf("beat %0d premium got %b want %b", beat_idx,
                                   out_tdata[1], want.premium));
          if (out_tdata[2] !== want.dropped)
            report_error($sformatf("beat %0d dropped got %b want %b", beat_idx,
                                   out_tdata[2], want.dropped));
          if (out_tdata[OutDataW-1:3] !== '0)
            report_error($sformatf("beat %0d pad bits got %h", beat_idx,
                                   out_tdata[OutDataW-1:3]));
        end
        beat_idx++;
      end
    end
  end

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  task automatic send_req(input func_t fn, input logic [31:0] ip, input logic cls,
                          input logic [31:0] now);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, now, cls, ip};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_verdicts.push_back(cache_predict(fn, ip, cls, now));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_DB_FAIL_LIMIT:  lim_fail   = val[7:0];
      REG_FAIL_CHECK_LIM: lim_forced = val[15:0];
      REG_SWEEP_INTERVAL: sweep_gap  = val;
      default:            lifetime   = val;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic refill_pool();
    for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = $urandom;
  endtask

  // Random request mix; the remainder after check, add and failure is ticks
  task automatic send_mixed(input int count, input int pct_check, input int pct_add,
                            input int pct_fail, input int max_step, input int pct_pool);
    int          roll;
    func_t       fn;
    logic [31:0] ip;
    logic [31:0] now;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_check) fn = FUNC_CHECK;
      else if (roll < pct_check + pct_add) fn = FUNC_ADD;
      else if (roll < pct_check + pct_add + pct_fail) fn = FUNC_FAIL;
      else fn = FUNC_TICK;
      ip = ($urandom_range(0, 99) < pct_pool) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : $urandom;
      wall_ms = wall_ms + $urandom_range(0, max_step);
      now = ($urandom_range(0, 99) < 3) ? $urandom : wall_ms;
      send_req(fn, ip, 1'($urandom_range(0, 1)), now);
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_req(FUNC_CHECK, 32'h0000_0000, 1'b0, 32'h0000_0000);
    send_req(FUNC_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
    // same address, other class, stamped at the top of the time range
    send_req(FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(FUNC_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd10);
    send_req(FUNC_ADD, 32'h0000_0000, 1'b1, 32'd100);
    send_req(FUNC_CHECK, 32'h0000_0000, 1'b0, 32'd150);
    send_req(FUNC_ADD, 32'h0000_0000, 1'b1, 32'd200);
    send_req(FUNC_TICK, 32'h0000_0000, 1'b0, 32'd5000);
    // sweep ages out all three, one of them exactly at the lifetime
    send_req(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 32'd3600100);
    send_req(FUNC_CHECK, 32'h0000_0000, 1'b0, 32'd3600101);
    repeat (6) send_req(FUNC_FAIL, $urandom, 1'b1, 32'd3600102);
    repeat (2) send_req(FUNC_CHECK, 32'hA5A5_5A5A, 1'b0, 32'd3600103);
    // count above the limit wraps back to one
    send_req(FUNC_FAIL, 32'h5A5A_A5A5, 1'b0, 32'd3600104);
    send_req(FUNC_CHECK, 32'hA5A5_5A5A, 1'b1, 32'd3600105);
    send_req(FUNC_ADD, 32'h1234_5678, 1'b1, 32'd3600200);
    send_req(FUNC_CHECK, 32'h1234_5678, 1'b0, 32'd3600201);
    wall_ms = 32'd3600201;
  endtask

  task automatic test_table_fill();
    set_idling(0, 71);
    refill_pool();
    send_mixed(100, 12, 80, 0, 50, 15);
  endtask

  task automatic test_failure_mode();
    int fails;
    set_idling(71, 0);
    wait_quiet();
    write_reg(REG_DB_FAIL_LIMIT, 32'hDEAD_BE00);
    write_reg(REG_FAIL_CHECK_LIM, 32'h5A5A_0003);
    send_mixed(50, 45, 10, 40, 20, 80);
    wait_quiet();
    write_reg(REG_FAIL_CHECK_LIM, 32'h0000_0000);
    send_mixed(25, 50, 5, 45, 20, 80);
    wait_quiet();
    write_reg(REG_FAIL_CHECK_LIM, 32'h0000_FFFF);
    write_reg(REG_DB_FAIL_LIMIT, 32'h0000_00FF);
    // start the climb from zero
    send_req(FUNC_ADD, addr_pool[0], 1'b0, wall_ms);
    // climb the count all the way past the largest limit
    fails = 0;
    while (fails < 256) begin
      if ($urandom_range(0, 99) < 12) begin
        send_req(FUNC_CHECK, addr_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b0, wall_ms);
      end else begin
        send_req(FUNC_FAIL, $urandom, 1'($urandom_range(0, 1)), wall_ms);
        fails++;
      end
    end
    repeat (4) send_req(FUNC_CHECK, $urandom, 1'b1, wall_ms);
    send_req(FUNC_FAIL, $urandom, 1'b0, wall_ms);
    send_req(FUNC_CHECK, addr_pool[0], 1'b0, wall_ms);
    wait_quiet();
  endtask

  task automatic test_expiry();
    set_idling(7, 7);
    write_reg(REG_SWEEP_INTERVAL, 32'd0);
    write_reg(REG_ENTRY_LIFETIME, 32'd0);
    write_reg(REG_DB_FAIL_LIMIT, 32'd3);
    send_mixed(30, 30, 40, 0, 10, 70);
    wait_quiet();
    write_reg(REG_SWEEP_INTERVAL, 32'd50);
    write_reg(REG_ENTRY_LIFETIME, 32'd300);
    send_mixed(50, 30, 40, 5, 40, 70);
    wait_quiet();
    write_reg(REG_SWEEP_INTERVAL, 32'hFFFF_FFFF);
    write_reg(REG_ENTRY_LIFETIME, 32'hFFFF_FFFF);
    // run across the wrap of the millisecond counter
    wall_ms = 32'hFFFF_FF00;
    send_mixed(25, 30, 40, 5, 40, 70);
    // tick one below the last sweep: the gap is the full range, so it sweeps
    send_req(FUNC_ADD, addr_pool[1], 1'b1, last_sweep_ms);
    send_req(FUNC_TICK, addr_pool[1], 1'b0, last_sweep_ms - 32'd1);
    send_req(FUNC_CHECK, addr_pool[1], 1'b0, wall_ms);
    wait_quiet();
  endtask

  task automatic test_mixed_defaults();
    set_idling(0, 0);
    write_reg(REG_DB_FAIL_LIMIT, {24'd0, RstDbFailLimit});
    write_reg(REG_FAIL_CHECK_LIM, {16'd0, RstFailCheckLim});
    write_reg(REG_SWEEP_INTERVAL, RstSweepIntv);
    write_reg(REG_ENTRY_LIFETIME, RstLifetime);
    refill_pool();
    send_mixed(60, 35, 30, 20, 500, 80);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    wall_ms     = '0;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      slot_used[s] = 1'b0;
      slot_ip[s]   = '0;
      slot_prem[s] = 1'b0;
      slot_born[s] = '0;
    end
    fail_cnt      = '0;
    forced_cnt    = '0;
    last_sweep_ms = '0;
    lim_fail      = RstDbFailLimit;
    lim_forced    = RstFailCheckLim;
    sweep_gap     = RstSweepIntv;
    lifetime      = RstLifetime;
    set_idling(0, 0);
    refill_pool();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_fill();
    test_failure_mode();
    test_expiry();
    test_mixed_defaults();

    wait_quiet();
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: ip_class_cache_with_ttl_unit.f
rtl/ictc_pkg.sv
rtl/ictc_regs.sv
rtl/ictc_ctrl.sv
rtl/ictc_dp.sv
rtl/ip_class_cache_with_ttl_unit.sv
verif/tb_ip_class_cache_with_ttl_unit.sv
